>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key-value cache
// Sizes, codes, state encoding and the command structs passed between the
// sequencer, the key/value store and the recency tracker.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Number of cache slots.
  localparam int ENTRIES = 16;
  // Slot index width; one bit at least so a single-slot cache still elaborates.
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Fill count width; it must hold ENTRIES itself.
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_PROMOTE,
    RK_INSERT
  } rank_op_t;

  // Recency update: promote ages the entries more recent than limit,
  // insert ages every valid entry and marks the slot valid.
  typedef struct packed {
    rank_op_t op;
    idx_t     slot;
    idx_t     limit;
  } rank_cmd_t;

  // One access of the key/value memories per cycle.
  typedef struct packed {
    logic  rd_en;
    logic  wr_key;
    logic  wr_val;
    idx_t  addr;
    word_t key;
    word_t value;
  } store_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage

>>> rtl/lkv_ifs.sv
// ----------------------------------------------------------------------------
// lkv_ifs: handshake channels of the LRU key-value cache
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface lkv_req_if;
  import lkv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] lookup_key;
  logic signed [DATA_W-1:0] write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkv_rsp_if;
  import lkv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;

  modport source (output valid, output hit, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  output ready);
endinterface

interface lkv_cfg_if;
  import lkv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store: key and value memories
// One address per cycle; writes and registered reads share that address.
// ----------------------------------------------------------------------------
module lkv_store (
  input  logic                clk,
  input  lkv_pkg::store_cmd_t cmd,
  output lkv_pkg::word_t      rd_key,
  output lkv_pkg::word_t      rd_value
);
  import lkv_pkg::*;

  word_t key_mem [ENTRIES];
  word_t val_mem [ENTRIES];
  word_t rd_key_r;
  word_t rd_value_r;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      key_mem[cmd.addr] <= cmd.key;
    end
    if (cmd.wr_val) begin
      val_mem[cmd.addr] <= cmd.value;
    end
    if (cmd.rd_en) begin
      rd_key_r   <= key_mem[cmd.addr];
      rd_value_r <= val_mem[cmd.addr];
    end
  end

  assign rd_key   = rd_key_r;
  assign rd_value = rd_value_r;

endmodule

>>> rtl/lkv_rank.sv
// ----------------------------------------------------------------------------
// lkv_rank: valid marks, recency ranks and fill count
// Rank 0 is the most recent entry; all ranks age together.
// ----------------------------------------------------------------------------
module lkv_rank (
  input  logic                clk,
  input  logic                rst_n,
  input  lkv_pkg::rank_cmd_t  cmd,
  output logic [lkv_pkg::ENTRIES-1:0] valid_vec,
  output lkv_pkg::idx_t       ranks [lkv_pkg::ENTRIES],
  output lkv_pkg::count_t     fill
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  idx_t               rank_r   [ENTRIES];
  idx_t               rank_nxt [ENTRIES];
  count_t             fill_r, fill_nxt;

  // Age the entries more recent than the target (all valid ones on an insert),
  // then make the target the most recent; an insert also marks it valid.
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    fill_nxt  = fill_r;
    case (cmd.op)
      RK_PROMOTE, RK_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (idx_t'(i) != cmd.slot && valid_r[i] &&
              (cmd.op == RK_INSERT || rank_r[i] < cmd.limit)) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        rank_nxt[cmd.slot] = '0;
        if (cmd.op == RK_INSERT) begin
          valid_nxt[cmd.slot] = 1'b1;
          fill_nxt            = fill_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      rank_r  <= rank_nxt;
    end
  end

  assign valid_vec = valid_r;
  assign ranks     = rank_r;
  assign fill      = fill_r;

endmodule

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl: lookup sequencer
// Scans each slot in turn (read state, then compare state) through a single
// key and rank compare, then applies the get or put and holds the result item.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  lkv_req_if.sink             in_if,
  lkv_rsp_if.source           out_if,
  input  lkv_pkg::count_t     eff_cap,
  input  logic [lkv_pkg::ENTRIES-1:0] valid_vec,
  input  lkv_pkg::idx_t       ranks [lkv_pkg::ENTRIES],
  input  lkv_pkg::count_t     fill,
  input  lkv_pkg::word_t      rd_key,
  input  lkv_pkg::word_t      rd_value,
  output lkv_pkg::store_cmd_t store_cmd,
  output lkv_pkg::rank_cmd_t  rank_cmd
);
  import lkv_pkg::*;

  localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

  state_t  state_r, state_nxt;
  idx_t    idx_r;
  opcode_t op_r;
  word_t   key_r;
  word_t   val_r;

  logic    found_r;
  idx_t    found_idx_r;
  idx_t    found_rank_r;
  word_t   found_val_r;
  logic    free_r;
  idx_t    free_idx_r;
  logic    vict_r;
  idx_t    vict_idx_r;
  idx_t    best_r;

  logic    res_hit_r, res_ev_r;
  word_t   res_rd_r;
  logic    res_hit_nxt, res_ev_nxt;
  word_t   res_rd_nxt;

  logic    out_valid_r;
  logic    out_hit_r, out_ev_r;
  word_t   out_rd_r;

  logic    in_ready;
  logic    accept;
  logic    res_load;
  logic    out_load;

  logic    cur_valid;
  idx_t    cur_rank;
  logic    cur_match;

  assign accept    = in_if.valid && in_ready;
  assign cur_valid = valid_vec[idx_r];
  assign cur_rank  = ranks[idx_r];
  assign cur_match = cur_valid && (rd_key == key_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_if.valid) state_nxt = S_READ;
      S_READ:   state_nxt = S_CMP;
      S_CMP:    state_nxt = (idx_r == LAST_IDX) ? S_UPDATE : S_READ;
      S_UPDATE: state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_if.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory access, recency update, result.
  always_comb begin
    in_ready        = 1'b0;
    res_load        = 1'b0;
    out_load        = 1'b0;
    store_cmd       = '0;
    store_cmd.key   = key_r;
    store_cmd.value = val_r;
    rank_cmd        = '0;
    rank_cmd.op     = RK_NONE;
    res_hit_nxt     = 1'b0;
    res_ev_nxt      = 1'b0;
    res_rd_nxt      = PUT_VALUE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ: begin
        store_cmd.rd_en = 1'b1;
        store_cmd.addr  = idx_r;
      end
      S_UPDATE: begin
        res_load = 1'b1;
        if (op_r == OP_GET) begin
          if (found_r) begin
            res_hit_nxt    = 1'b1;
            res_rd_nxt     = found_val_r;
            rank_cmd.op    = RK_PROMOTE;
            rank_cmd.slot  = found_idx_r;
            rank_cmd.limit = found_rank_r;
          end else begin
            res_rd_nxt = MISS_VALUE;
          end
        end else if (found_r) begin
          // Update of a present key.
          res_hit_nxt      = 1'b1;
          store_cmd.wr_val = 1'b1;
          store_cmd.addr   = found_idx_r;
          rank_cmd.op      = RK_PROMOTE;
          rank_cmd.slot    = found_idx_r;
          rank_cmd.limit   = found_rank_r;
        end else if (fill < eff_cap) begin
          // Room left: fill the lowest free slot.
          if (free_r) begin
            store_cmd.wr_key = 1'b1;
            store_cmd.wr_val = 1'b1;
            store_cmd.addr   = free_idx_r;
            rank_cmd.op      = RK_INSERT;
            rank_cmd.slot    = free_idx_r;
          end
        end else if (vict_r) begin
          // Full: replace the least recent entry.
          res_ev_nxt       = 1'b1;
          store_cmd.wr_key = 1'b1;
          store_cmd.wr_val = 1'b1;
          store_cmd.addr   = vict_idx_r;
          rank_cmd.op      = RK_PROMOTE;
          rank_cmd.slot    = vict_idx_r;
          rank_cmd.limit   = best_r;
        end
      end
      S_DONE: begin
        out_load = !out_valid_r || out_if.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture and the per-slot scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode_t'(in_if.opcode);
      key_r   <= $unsigned(in_if.lookup_key);
      val_r   <= $unsigned(in_if.write_value);
      idx_r   <= '0;
      found_r <= 1'b0;
      free_r  <= 1'b0;
      vict_r  <= 1'b0;
    end else if (state_r == S_CMP) begin
      idx_r <= idx_r + 1'b1;
      if (cur_match && !found_r) begin
        found_r      <= 1'b1;
        found_idx_r  <= idx_r;
        found_rank_r <= cur_rank;
        found_val_r  <= rd_value;
      end
      if (!cur_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (cur_valid && (!vict_r || cur_rank > best_r)) begin
        vict_r     <= 1'b1;
        vict_idx_r <= idx_r;
        best_r     <= cur_rank;
      end
    end
  end

  // Pending result, then the output register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_hit_r <= res_hit_nxt;
      res_rd_r  <= res_rd_nxt;
      res_ev_r  <= res_ev_nxt;
    end
    if (out_load) begin
      out_hit_r <= res_hit_r;
      out_rd_r  <= res_rd_r;
      out_ev_r  <= res_ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.hit        = out_hit_r;
  assign out_if.read_value = $signed(out_rd_r);
  assign out_if.evicted    = out_ev_r;

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Top level: capacity register, store, recency tracker and sequencer.
// ----------------------------------------------------------------------------
// Request items are taken one at a time; the next is accepted only once the
// sequencer is back in idle: it scans the slots one at a time through the
// single read port of the key/value memory, a read state and a compare state
// per slot, then applies the update in the update state and loads the
// response register in the done state. The response waits in its register
// while the next request is taken; a response that is still not taken when
// the next one is ready holds the sequencer until it leaves. Valid marks,
// ranks and the fill count clear at reset; no clearing pass is needed. The
// capacity register reads 0 as 1 and saturates at the slot count, and may be
// written only while no request is in flight.
module lru_key_value_cache (
  input  logic      clk,
  input  logic      rst_n,
  lkv_req_if.sink   in_if,
  lkv_rsp_if.source out_if,
  lkv_cfg_if.sink   cfg_if
);
  import lkv_pkg::*;

  logic [CAP_W-1:0]   cap_r;
  count_t             eff_cap;
  store_cmd_t         store_cmd;
  rank_cmd_t          rank_cmd;
  word_t              rd_key;
  word_t              rd_value;
  logic [ENTRIES-1:0] valid_vec;
  idx_t               ranks [ENTRIES];
  count_t             fill;

  // Capacity register.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_if.valid) begin
      cap_r <= cfg_if.data;
    end
  end

  // Effective capacity: zero reads as one, large values clamp to the slot count.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = count_t'(1);
    end else if (32'(cap_r) > 32'(ENTRIES)) begin
      eff_cap = count_t'(ENTRIES);
    end else begin
      eff_cap = count_t'(cap_r);
    end
  end

  lkv_store u_store (
    .clk      (clk),
    .cmd      (store_cmd),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  lkv_rank u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rank_cmd),
    .valid_vec (valid_vec),
    .ranks     (ranks),
    .fill      (fill)
  );

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .eff_cap   (eff_cap),
    .valid_vec (valid_vec),
    .ranks     (ranks),
    .fill      (fill),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .store_cmd (store_cmd),
    .rank_cmd  (rank_cmd)
  );

  // The fill count always matches the number of valid slots.
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(fill))
    else $error("fill count differs from number of valid slots");

  // A response never reports both a hit and an eviction.
  a_hit_excludes_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.hit && out_if.evicted))
    else $error("response carries both hit and evicted");

  // Once a request item is taken, the next one waits for the scan.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request taken while a lookup is in progress");

  // Inserts never push the fill count past the slot count.
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill) <= 32'(ENTRIES))
    else $error("fill count exceeds slot count");

endmodule

>>> dv/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache
// Drives get and put items through the request channel, tracks the expected
// cache contents and recency order in a scoreboard, and checks every response
// item field by field. Capacity is changed between phases while the cache is
// idle, including the zero and oversized settings.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int LATENCY_CYCLES = 2 * ENTRIES + 3;
  localparam int SETTLE_CYCLES  = LATENCY_CYCLES + 5;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int PHASE_ITEMS    = 180;
  localparam int NUM_PHASES     = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic  hit;
    word_t read_value;
    logic  evicted;
  } cache_resp_t;

  // Scoreboard: mirrors the cache contents and recency ranks, and queues the
  // response expected for each accepted request item.
  class cache_scoreboard;
    word_t            slot_key   [ENTRIES];
    word_t            slot_value [ENTRIES];
    bit               slot_valid [ENTRIES];
    int unsigned      slot_rank  [ENTRIES];
    int unsigned      fill_count;
    logic [CAP_W-1:0] capacity;
    cache_resp_t      expected_responses[$];
    int unsigned      accesses;
    int unsigned      responses;
    int unsigned      mismatches;
    int unsigned      hits;
    int unsigned      evictions;

    function new();
      foreach (slot_valid[i]) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
      fill_count = 0;
      capacity   = CAP_RESET;
      accesses   = 0;
      responses  = 0;
      mismatches = 0;
      hits       = 0;
      evictions  = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    // Zero reads as one slot, anything above the slot count saturates.
    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > ENTRIES) return ENTRIES;
      return 32'(capacity);
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    // Slot s becomes most recent; valid entries newer than limit age by one.
    function void make_recent(int s, longint unsigned limit);
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != s && slot_valid[i] && slot_rank[i] < limit) slot_rank[i]++;
      end
      slot_rank[s] = 0;
    endfunction

    // Applies one access to the mirrored cache and returns its response.
    function cache_resp_t predict_access(opcode_t op, word_t key, word_t value);
      cache_resp_t resp;
      int          found;
      int          slot;
      int          victim;
      int unsigned oldest;
      resp.hit        = 1'b0;
      resp.read_value = (op == OP_GET) ? MISS_VALUE : PUT_VALUE;
      resp.evicted    = 1'b0;
      found  = -1;
      slot   = -1;
      victim = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      end
      if (found >= 0) begin
        resp.hit = 1'b1;
        if (op == OP_GET) resp.read_value = slot_value[found];
        else slot_value[found] = value;
        make_recent(found, slot_rank[found]);
      end else if (op == OP_PUT) begin
        if (fill_count < usable_slots()) begin
          // Lowest free slot, every valid entry ages.
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !slot_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            make_recent(slot, 64'hFFFF_FFFF_FFFF_FFFF);
            slot_key[slot]   = key;
            slot_value[slot] = value;
            slot_valid[slot] = 1'b1;
            fill_count++;
          end
        end else begin
          // Replace the least recent valid entry; fill count is unchanged.
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_rank[i] > oldest)) begin
              victim = i;
              oldest = slot_rank[i];
            end
          end
          if (victim >= 0) begin
            resp.evicted = 1'b1;
            make_recent(victim, oldest);
            slot_key[victim]   = key;
            slot_value[victim] = value;
          end
        end
      end
      return resp;
    endfunction

    function void note_access(opcode_t op, word_t key, word_t value);
      cache_resp_t resp;
      resp = predict_access(op, key, value);
      expected_responses.push_back(resp);
      accesses++;
      if (resp.hit) hits++;
      if (resp.evicted) evictions++;
    endfunction

    function void check_response(cache_resp_t got);
      cache_resp_t want;
      responses++;
      if (expected_responses.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected response item %0d: hit %0b value %h evicted %0b",
                   responses, got.hit, got.read_value, got.evicted);
        mismatches++;
        return;
      end
      want = expected_responses.pop_front();
      if (got.hit !== want.hit || got.read_value !== want.read_value ||
          got.evicted !== want.evicted) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("mismatch on response item %0d (expected/actual):", responses);
          $display("  hit %0b/%0b value %h/%h evicted %0b/%0b",
                   want.hit, got.hit, want.read_value, got.read_value,
                   want.evicted, got.evicted);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();
  lkv_cfg_if cfg_ch ();

  lru_key_value_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch),
    .cfg_if (cfg_ch)
  );

  cache_scoreboard  sb = new();
  bit               idle_on  = 1'b1;
  bit               hold_req = 1'b0;
  int unsigned      cycle_count = 0;
  logic [CAP_W-1:0] phase_caps [NUM_PHASES] = '{16, 1, 5, 31, 0, 12, 3, 16};

  // Clock.
  always #1 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response side: sample at the rising edge, choose ready at the falling one.
  initial begin : response_side
    int unsigned stall_left;
    int unsigned hold_left;
    cache_resp_t got;
    stall_left   = 0;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        got.hit        = rsp_ch.hit;
        got.read_value = rsp_ch.read_value;
        got.evicted    = rsp_ch.evicted;
        sb.check_response(got);
      end
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 8);
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Offers one request item and returns at the falling edge after it is taken.
  // Valid stays high so back-to-back items need no gap.
  task automatic send_access(opcode_t op, word_t key, word_t value);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.opcode      = op;
    req_ch.lookup_key  = key;
    req_ch.write_value = value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_access(op, key, value);
    @(negedge clk);
  endtask

  // Lets the cache drain completely, then writes the capacity register.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_capacity(cap);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Random gets and puts over a key pool a little larger than the capacity,
  // so hits, misses, updates and evictions all occur often.
  task automatic run_random_phase(int unsigned items);
    word_t       pool[$];
    int unsigned pool_size;
    word_t       key;
    opcode_t     op;
    pool_size = sb.usable_slots() + $urandom_range(1, 4);
    repeat (pool_size) begin
      case ($urandom_range(0, 7))
        0:       pool.push_back(32'h8000_0000);
        1:       pool.push_back(32'h7FFF_FFFF);
        2:       pool.push_back(32'hFFFF_FFFF);
        3:       pool.push_back(32'h0000_0000);
        default: pool.push_back($urandom);
      endcase
    end
    repeat (items) begin
      if ($urandom_range(0, 19) == 0) key = $urandom;
      else key = pool[$urandom_range(0, pool.size() - 1)];
      op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
      send_access(op, key, $urandom);
    end
  endtask

  initial begin : stimulus
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_GET;
    req_ch.lookup_key  = '0;
    req_ch.write_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty lookup, extreme keys and values, hits and an update.
    send_access(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_access(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h0000_0001, 32'h0000_0000);

    // Capacity lowered below the fill count: new keys replace the oldest.
    write_capacity(2);
    send_access(OP_PUT, 32'h0000_0005, 32'h0000_0055);
    send_access(OP_PUT, 32'h0000_0006, 32'h0000_0066);
    send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);

    // Capacity zero behaves as one slot.
    write_capacity(0);
    send_access(OP_PUT, 32'h0000_0007, 32'h0000_0077);
    send_access(OP_GET, 32'h0000_0007, 32'h0000_0000);
    send_access(OP_PUT, 32'h0000_0008, 32'h0000_0088);
    send_access(OP_GET, 32'h0000_0007, 32'h0000_0000);

    // Oversized capacity saturates at the slot count.
    write_capacity(31);
    send_access(OP_PUT, 32'h0000_0009, 32'h0000_0099);
    send_access(OP_GET, 32'h0000_0009, 32'h0000_0000);

    // Random phases; the second starts with a long response hold-off, the
    // fourth and the last run without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      idle_on = (p != 3 && p != NUM_PHASES - 1);
      if (p == 1) hold_req = 1'b1;
      run_random_phase(PHASE_ITEMS);
    end

    // Drain and let the block settle before the verdict.
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d get/put items across %0d capacity settings, zero and 31 included.",
             sb.accesses, NUM_PHASES + 3);
    $display("%0d hits, %0d evictions, %0d responses checked, %0d mismatches, %0d missing.",
             sb.hits, sb.evictions, sb.responses, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
